/* rtl/lev_pkg.sv */
// Shared types and constants for the Levenshtein distance block.
// Used by lev_cell and levenshtein_distance_linear_space; no dependencies.
package lev_pkg;

  localparam int MAX_LEN = 1024;                  // longest u or v kept
  localparam int CW      = $clog2(MAX_LEN + 1);   // cost / count width
  localparam int DIST_W  = 11;                    // distance port width
  localparam int SYM_W   = 8;
  localparam int REQ_W   = 2;

  // Request codes on req_type
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WAVE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  // Token kinds moving down the chain
  typedef enum logic [1:0] {
    TOK_LOAD,
    TOK_WAVE,
    TOK_FIN
  } lev_kind_e;

  // One token per cycle per cell.
  //   load:   tgt = row index to fill, sym = symbol
  //   wave:   sym = v symbol, up = new cost of row above, diag = old cost of row above
  //   finish: tgt = row count, up = distance so far, ovf = dropped flag
  typedef struct packed {
    logic             valid;
    lev_kind_e        kind;
    logic [SYM_W-1:0] sym;
    logic [CW-1:0]    up;
    logic [CW-1:0]    diag;
    logic [CW-1:0]    tgt;
    logic             ovf;
  } lev_tok_t;

endpackage

/* rtl/levenshtein_distance_linear_space.sv */
// Top level of the Levenshtein distance block: request decode, job counters,
// the systolic row of lev_cell instances and the result port. Depends on lev_pkg, lev_cell.
//
// Usage
//   Input transaction: start with req_type_i / symbol_i, accepted on a rising edge
//   where start is high and busy is low.
//     req_type LOAD   appends a symbol of u (only before the first v symbol).
//     req_type WAVE   streams one symbol of v through the column.
//     req_type FINISH emits the distance and overflow flag, then clears the job.
//     Code 3 is ignored.
//   Output transaction: done_o high for exactly one cycle with distance_o and
//   overflow_o; the receiver cannot stall it, so it must take it then.
//   Throughput: one transaction per cycle, any mix of types. Every token enters
//   cell 1 at acceptance and moves one cell per cycle, so waves of successive v
//   symbols are in flight together down the chain.
//   A finish result shows on done_o once the finish token has walked the whole
//   cell chain, picking up the cost of the last loaded row and clearing each
//   cell as it goes.
//   Reset: asynchronous, active low; all cells return to cost k, no rows loaded.
//   busy is high during reset, is cleared by the clock once reset is released, then stays low.
module levenshtein_distance_linear_space (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lev_pkg::REQ_W-1:0]     req_type_i,
  input  logic [lev_pkg::SYM_W-1:0]     symbol_i,
  output logic                          done_o,
  output logic [lev_pkg::DIST_W-1:0]    distance_o,
  output logic                          overflow_o
);

  localparam logic [lev_pkg::CW-1:0] LenMax = lev_pkg::CW'(lev_pkg::MAX_LEN);

  logic                   busy_q;
  logic                   accept;
  logic [lev_pkg::CW-1:0] row_count_q, row_count_d;
  logic [lev_pkg::CW-1:0] col_count_q, col_count_d;
  logic                   dropped_q, dropped_d;

  lev_pkg::lev_tok_t      entry_tok;
  lev_pkg::lev_tok_t      chain [lev_pkg::MAX_LEN+1];

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Decode the request into counter updates and a token for the chain.
  always_comb begin
    row_count_d     = row_count_q;
    col_count_d     = col_count_q;
    dropped_d       = dropped_q;
    entry_tok       = '0;
    entry_tok.kind  = lev_pkg::TOK_WAVE;
    entry_tok.sym   = symbol_i;
    if (accept) begin
      case (req_type_i)
        lev_pkg::REQ_LOAD: begin
          // u after v started: silently ignored
          if (col_count_q == '0) begin
            if (row_count_q == LenMax) begin
              dropped_d = 1'b1;
            end else begin
              row_count_d     = row_count_q + lev_pkg::CW'(1);
              entry_tok.valid = 1'b1;
              entry_tok.kind  = lev_pkg::TOK_LOAD;
              entry_tok.tgt   = row_count_q + lev_pkg::CW'(1);
            end
          end
        end
        lev_pkg::REQ_WAVE: begin
          if (col_count_q == LenMax) begin
            dropped_d = 1'b1;
          end else begin
            col_count_d     = col_count_q + lev_pkg::CW'(1);
            entry_tok.valid = 1'b1;
            entry_tok.kind  = lev_pkg::TOK_WAVE;
            entry_tok.up    = col_count_q + lev_pkg::CW'(1);  // new cost[0]
            entry_tok.diag  = col_count_q;                    // old cost[0]
          end
        end
        lev_pkg::REQ_FINISH: begin
          // Distance starts as cost[0]; the cell at the last row overwrites it.
          entry_tok.valid = 1'b1;
          entry_tok.kind  = lev_pkg::TOK_FIN;
          entry_tok.up    = col_count_q;
          entry_tok.tgt   = row_count_q;
          entry_tok.ovf   = dropped_q;
          row_count_d     = '0;
          col_count_d     = '0;
          dropped_d       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      row_count_q <= '0;
      col_count_q <= '0;
      dropped_q   <= 1'b0;
    end else begin
      busy_q      <= 1'b0;
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      dropped_q   <= dropped_d;
    end
  end

  // Systolic row: cell k holds u[k-1] and cost[k].
  assign chain[0] = entry_tok;

  for (genvar k = 1; k <= lev_pkg::MAX_LEN; k++) begin : g_cell
    lev_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .index_i (lev_pkg::CW'(k)),
      .tok_i   (chain[k-1]),
      .tok_o   (chain[k])
    );
  end

  // Result comes straight from the last cell's token register.
  assign done_o     = chain[lev_pkg::MAX_LEN].valid &&
                      (chain[lev_pkg::MAX_LEN].kind == lev_pkg::TOK_FIN);
  assign distance_o = lev_pkg::DIST_W'(chain[lev_pkg::MAX_LEN].up);
  assign overflow_o = chain[lev_pkg::MAX_LEN].ovf;

  // Checks

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_count_q <= LenMax) && (col_count_q <= LenMax))
    else $error("job counter beyond MAX_LEN");

  a_wave_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == lev_pkg::REQ_WAVE) && (col_count_q != LenMax))
    |=> (col_count_q == $past(col_count_q) + lev_pkg::CW'(1)))
    else $error("v symbol accepted without advancing column count");

  a_no_load_after_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == lev_pkg::REQ_LOAD) && (col_count_q != '0))
    |=> $stable(row_count_q))
    else $error("u symbol loaded after v started");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (chain[lev_pkg::MAX_LEN].up <= LenMax))
    else $error("distance beyond MAX_LEN");

endmodule

/* rtl/lev_cell.sv */
// One row of the DP column: holds u[index-1] and cost[index], passes tokens on.
// Depends on lev_pkg.
module lev_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [lev_pkg::CW-1:0] index_i,
  input  lev_pkg::lev_tok_t     tok_i,
  output lev_pkg::lev_tok_t     tok_o
);

  logic [lev_pkg::CW-1:0]    cost_q, cost_d;
  logic                      active_q, active_d;
  logic [lev_pkg::SYM_W-1:0] sym_q, sym_d;
  lev_pkg::lev_tok_t         tok_q, tok_d;

  logic [lev_pkg::CW-1:0] cand_rep, cand_del, cand_ins, best;

  always_comb begin
    cand_rep = tok_i.diag + ((sym_q != tok_i.sym) ? lev_pkg::CW'(1) : lev_pkg::CW'(0));
    cand_del = tok_i.up + lev_pkg::CW'(1);
    cand_ins = cost_q + lev_pkg::CW'(1);
    best     = cand_rep;
    if (cand_del < best) best = cand_del;
    if (cand_ins < best) best = cand_ins;
  end

  always_comb begin
    cost_d   = cost_q;
    active_d = active_q;
    sym_d    = sym_q;
    tok_d    = tok_i;
    if (tok_i.valid) begin
      case (tok_i.kind)
        lev_pkg::TOK_WAVE: begin
          if (active_q) begin
            tok_d.up   = best;
            tok_d.diag = cost_q;
            cost_d     = best;
          end
        end
        lev_pkg::TOK_LOAD: begin
          if (tok_i.tgt == index_i) begin
            sym_d       = tok_i.sym;
            active_d    = 1'b1;
            tok_d.valid = 1'b0;   // consumed here
          end
        end
        lev_pkg::TOK_FIN: begin
          if (tok_i.tgt == index_i) tok_d.up = cost_q;
          cost_d   = index_i;     // job clear as the token sweeps past
          active_d = 1'b0;
        end
        default: begin
          tok_d.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q   <= index_i;
      active_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      cost_q   <= cost_d;
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  // stored u symbol, no reset
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign tok_o = tok_q;

endmodule

/* verif/levenshtein_distance_linear_space_tb.sv */
// Self-checking testbench for levenshtein_distance_linear_space.
// Drives load / wave / finish transactions, predicts each distance internally and
// checks every done_o result. Depends on lev_pkg and the block's RTL.
`timescale 1ns / 100ps

module levenshtein_distance_linear_space_tb;

  // Code 3 has no meaning for the block; it must be dropped silently.
  localparam logic [lev_pkg::REQ_W-1:0] REQ_UNDEF = 2'd3;
  // After the last result, watch for strays as long as one finish takes to walk
  // the chain, plus some margin.
  localparam int DRAIN_CYCLES = lev_pkg::MAX_LEN + 64;

  // One pending request: gap = idle cycles before it is presented.
  typedef struct packed {
    logic [lev_pkg::REQ_W-1:0] req;
    logic [lev_pkg::SYM_W-1:0] sym;
    logic [15:0]               gap;
  } edit_req_t;

  // One predicted finish result.
  typedef struct packed {
    logic [lev_pkg::DIST_W-1:0] distance;
    logic                       ovf;
  } edit_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       start      = 1'b0;
  logic [lev_pkg::REQ_W-1:0]  req_type_i = '0;
  logic [lev_pkg::SYM_W-1:0]  symbol_i   = '0;
  logic                       busy;
  logic                       done_o;
  logic [lev_pkg::DIST_W-1:0] distance_o;
  logic                       overflow_o;

  levenshtein_distance_linear_space u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .symbol_i   (symbol_i),
    .done_o     (done_o),
    .distance_o (distance_o),
    .overflow_o (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  edit_req_t    req_q[$];   // requests not yet presented
  edit_result_t dist_q[$];  // predicted distances, oldest first

  int n_err       = 0;
  int n_checked   = 0;
  int n_load      = 0;
  int n_wave      = 0;
  int n_finish    = 0;
  int n_undef     = 0;
  int n_ovf_seen  = 0;   // predicted results carrying overflow
  int n_queued    = 0;
  int total_gap   = 0;
  int calm_left   = 0;   // remaining requests in a no-idle stretch
  int n_jobs      = 0;
  int gap_left    = 0;
  int cycles      = 0;
  int cycle_limit = 32'h7fff_ffff;
  bit timed_out   = 1'b0;
  bit slot_free;

  // ---------------------------------------------------------------------------
  // Predictor state: u symbols, the single DP column and the job counters.
  // ---------------------------------------------------------------------------
  logic [lev_pkg::SYM_W-1:0] u_sym [lev_pkg::MAX_LEN];
  int                        cost  [lev_pkg::MAX_LEN+1];
  int                        u_len;
  int                        v_len;
  bit                        dropped;

  task automatic clear_job();
    int k;
    for (k = 0; k <= lev_pkg::MAX_LEN; k++) cost[k] = k;
    u_len   = 0;
    v_len   = 0;
    dropped = 1'b0;
  endtask

  // Apply one accepted transaction to the predicted state; a finish queues the
  // expected distance.
  task automatic edit_step(input logic [lev_pkg::REQ_W-1:0] req,
                           input logic [lev_pkg::SYM_W-1:0] sym);
    int           r;
    int           diag;
    int           left;
    int           best;
    edit_result_t res;
    case (req)
      lev_pkg::REQ_LOAD: begin
        n_load++;
        // u is frozen once v has started; such loads vanish without a flag
        if (v_len == 0) begin
          if (u_len >= lev_pkg::MAX_LEN) begin
            dropped = 1'b1;
          end else begin
            u_sym[u_len] = sym;
            u_len++;
            cost[u_len] = u_len;
          end
        end
      end
      lev_pkg::REQ_WAVE: begin
        n_wave++;
        if (v_len >= lev_pkg::MAX_LEN) begin
          dropped = 1'b1;   // column left as it is
        end else begin
          v_len++;
          diag    = cost[0];
          cost[0] = v_len;
          for (r = 1; r <= u_len; r++) begin
            left = cost[r];
            best = diag + ((u_sym[r-1] == sym) ? 0 : 1);
            if (cost[r-1] + 1 < best) best = cost[r-1] + 1;
            if (left + 1 < best) best = left + 1;
            cost[r] = best;
            diag    = left;
          end
        end
      end
      lev_pkg::REQ_FINISH: begin
        n_finish++;
        res.distance = cost[u_len][lev_pkg::DIST_W-1:0];
        res.ovf      = dropped;
        if (dropped) n_ovf_seen++;
        dist_q.push_back(res);
        clear_job();
      end
      default: n_undef++;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap();
    int p;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    p = $urandom_range(99);
    if (p < 3) calm_left = $urandom_range(60, 10);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(16, 4);
    return $urandom_range(120, 17);
  endfunction

  // Narrow alphabet gives plenty of matches; full range exercises every bit.
  function automatic logic [lev_pkg::SYM_W-1:0] pick_sym(
      input logic [lev_pkg::SYM_W-1:0] base, input bit narrow);
    if (narrow) return base + lev_pkg::SYM_W'($urandom_range(3));
    return lev_pkg::SYM_W'($urandom_range(255));
  endfunction

  // Sequence lengths: mostly tiny, sometimes moderate.
  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(6);
    if (p < 95) return $urandom_range(20, 7);
    return $urandom_range(48, 21);
  endfunction

  task automatic queue_req(input logic [lev_pkg::REQ_W-1:0] req,
                           input logic [lev_pkg::SYM_W-1:0] sym);
    edit_req_t it;
    it.req = req;
    it.sym = sym;
    it.gap = 16'(pick_gap());
    total_gap += it.gap;
    n_queued++;
    req_q.push_back(it);
  endtask

  // One job: ulen loads, vlen waves, a finish. Noisy jobs sprinkle undefined
  // codes and late loads (after v has started) that must be ignored.
  task automatic queue_job(input int ulen, input int vlen, input bit narrow,
                           input bit noisy);
    logic [lev_pkg::SYM_W-1:0] base;
    int                        k;
    base = lev_pkg::SYM_W'($urandom_range(255));
    for (k = 0; k < ulen; k++) begin
      if (noisy && $urandom_range(9) == 0)
        queue_req(REQ_UNDEF, lev_pkg::SYM_W'($urandom_range(255)));
      queue_req(lev_pkg::REQ_LOAD, pick_sym(base, narrow));
    end
    for (k = 0; k < vlen; k++) begin
      if (noisy && $urandom_range(9) == 0)
        queue_req(REQ_UNDEF, lev_pkg::SYM_W'($urandom_range(255)));
      queue_req(lev_pkg::REQ_WAVE, pick_sym(base, narrow));
      if (noisy && $urandom_range(19) == 0)
        queue_req(lev_pkg::REQ_LOAD, pick_sym(base, narrow));
    end
    queue_req(lev_pkg::REQ_FINISH, lev_pkg::SYM_W'($urandom_range(255)));
    n_jobs++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a transaction is taken at an edge with start high and busy low.
  // start stays high across back-to-back transactions (one NBA per edge).
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      req_type_i <= '0;
      symbol_i   <= '0;
      gap_left    = (req_q.size() > 0) ? req_q[0].gap : 0;
    end else begin
      if (start && !busy) begin
        edit_step(req_type_i, symbol_i);
        slot_free = 1'b1;
      end else begin
        slot_free = !start;
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          req_type_i <= req_q[0].req;
          symbol_i   <= req_q[0].sym;
          start      <= 1'b1;
          void'(req_q.pop_front());
          gap_left = (req_q.size() > 0) ? req_q[0].gap : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done_o lasts one cycle; compare with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what, input int want, input int got);
    n_err++;
    if (n_err <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    edit_result_t exp_res;
    if (rst_ni && done_o) begin
      if (dist_q.size() == 0) begin
        flag_error("unexpected result (nothing pending, expected -1)", -1, distance_o);
      end else begin
        exp_res = dist_q.pop_front();
        n_checked++;
        if (distance_o !== exp_res.distance)
          flag_error("distance", exp_res.distance, distance_o);
        if (overflow_o !== exp_res.ovf) flag_error("overflow", exp_res.ovf, overflow_o);
      end
    end
  end

  always @(posedge clk_i) cycles++;

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_job();

    // Directed jobs.
    // empty u and v: distance 0; finish symbol is don't-care
    queue_req(lev_pkg::REQ_FINISH, 8'hFF);
    // u only, symbol extremes: distance = |u|
    queue_req(lev_pkg::REQ_LOAD, 8'h00);
    queue_req(lev_pkg::REQ_LOAD, 8'hFF);
    queue_req(lev_pkg::REQ_FINISH, 8'h00);
    // v only: distance = |v|
    queue_req(lev_pkg::REQ_WAVE, 8'hFF);
    queue_req(lev_pkg::REQ_WAVE, 8'h00);
    queue_req(lev_pkg::REQ_WAVE, 8'h55);
    queue_req(lev_pkg::REQ_FINISH, 8'hAA);
    // identical strings with an undefined code in the middle: distance 0
    queue_req(lev_pkg::REQ_LOAD, 8'h61);
    queue_req(lev_pkg::REQ_LOAD, 8'h62);
    queue_req(REQ_UNDEF, 8'h61);
    queue_req(lev_pkg::REQ_WAVE, 8'h61);
    queue_req(lev_pkg::REQ_WAVE, 8'h62);
    queue_req(lev_pkg::REQ_FINISH, 8'h00);
    // late load after v started is dropped without overflow: distance 1
    queue_req(lev_pkg::REQ_LOAD, 8'h0F);
    queue_req(lev_pkg::REQ_WAVE, 8'hF0);
    queue_req(lev_pkg::REQ_LOAD, 8'hF0);
    queue_req(lev_pkg::REQ_FINISH, 8'h00);
    // swapped pair: distance 2
    queue_req(lev_pkg::REQ_LOAD, 8'h80);
    queue_req(lev_pkg::REQ_LOAD, 8'h01);
    queue_req(lev_pkg::REQ_WAVE, 8'h01);
    queue_req(lev_pkg::REQ_WAVE, 8'h80);
    queue_req(lev_pkg::REQ_FINISH, 8'h00);

    // Random jobs until at least 440 transactions are queued.
    n_jobs = 0;
    while (n_queued < 440) begin
      queue_job(pick_len(), pick_len(), 1'($urandom_range(1)), $urandom_range(3) == 0);
    end

    // Timeout bound, with margin: every gap, every request, four chain walks, reset.
    cycle_limit = 4 * (total_gap + n_queued + 4 * lev_pkg::MAX_LEN + 200);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        while (req_q.size() != 0 || start) @(posedge clk_i);
        while (dist_q.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      begin
        while (cycles < cycle_limit) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any

    $display("Sent %0d loads, %0d waves, %0d finishes, %0d undefined codes in %0d jobs, %0d cycles",
             n_load, n_wave, n_finish, n_undef, n_jobs, cycles);
    $display("Checked %0d distances (%0d with overflow), %0d mismatches, %0d left pending",
             n_checked, n_ovf_seen, n_err, dist_q.size());
    if (!timed_out && n_err == 0 && dist_q.size() == 0) begin
      $display("levenshtein_distance_linear_space_tb: PASS");
    end else begin
      $display("levenshtein_distance_linear_space_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lev_pkg.sv
rtl/lev_cell.sv
rtl/levenshtein_distance_linear_space.sv
verif/levenshtein_distance_linear_space_tb.sv
